### rtl/sqs_pkg.sv
// Package for the sample quantizer: field widths, datapath widths,
// register indexes and the structs passed between the top level and its units.
// No dependencies.
package sqs_pkg;

    localparam int W_SMP  = 32;            // Q16.16 sample and range ends
    localparam int W_CODE = 16;            // output code
    localparam int W_TOT  = 32;            // clip totals as seen on the ports
    localparam int W_DIF  = W_SMP + 1;     // signed difference of two samples
    localparam int D_W    = W_SMP;         // divisor: |span| < 2^32
    localparam int Q_W    = W_CODE + 1;    // quotient, also multiplier width
    localparam int P_W    = D_W + Q_W;     // product n * m

    localparam logic [1:0] REG_RANGE_LOW  = 2'd0;
    localparam logic [1:0] REG_RANGE_HIGH = 2'd1;
    localparam logic [1:0] REG_MAX_CODE   = 2'd2;
    localparam logic [1:0] REG_MASK_MODE  = 2'd3;

    localparam logic signed [W_SMP-1:0] SMP_MAX = {1'b0, {(W_SMP-1){1'b1}}};
    localparam logic signed [W_SMP-1:0] SMP_MIN = {1'b1, {(W_SMP-1){1'b0}}};

    // signed zero, so compares against differences stay signed
    localparam logic signed [W_DIF-1:0] DIF_ZERO = '0;

    // one finished sample, committed to the statistics
    typedef struct packed {
        logic                    restart;
        logic signed [W_SMP-1:0] sample;
        logic [W_CODE-1:0]       code;
        logic                    low_clip;
        logic                    high_clip;
    } t_upd;

    // statistics as they stand with the committed sample included
    typedef struct packed {
        logic signed [W_SMP-1:0] in_min;
        logic signed [W_SMP-1:0] in_max;
        logic [W_CODE-1:0]       code_min;
        logic [W_CODE-1:0]       code_max;
        logic [W_TOT-1:0]        low_total;
        logic [W_TOT-1:0]        high_total;
    } t_stats;

endpackage

### rtl/sqs_div.sv
// Restoring radix-2 divider, one quotient bit per cycle through a single
// compare/subtract unit. Dividend must satisfy dividend >> Q_W < divisor.
// Depends on sqs_pkg.
module sqs_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [sqs_pkg::P_W-1:0]    i_dividend,
    input  logic [sqs_pkg::D_W-1:0]    i_divisor,
    output logic                       o_done,
    output logic [sqs_pkg::Q_W-1:0]    o_quot,
    output logic [sqs_pkg::D_W-1:0]    o_rem
);

    localparam int CW = $clog2(sqs_pkg::Q_W + 1);

    logic [sqs_pkg::D_W-1:0] r_rem;
    logic [sqs_pkg::Q_W-1:0] r_low;   // dividend bits going in, quotient bits coming out
    logic [sqs_pkg::D_W-1:0] r_dvs;
    logic [CW-1:0]           r_cnt;
    logic                    r_busy;
    logic                    r_done;

    logic [sqs_pkg::D_W:0] trial;
    logic [sqs_pkg::D_W:0] diff;
    logic                  ge;

    assign trial = {r_rem, r_low[sqs_pkg::Q_W-1]};
    assign ge    = trial >= {1'b0, r_dvs};
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(sqs_pkg::Q_W);
                r_rem  <= i_dividend[sqs_pkg::P_W-1:sqs_pkg::Q_W];
                r_low  <= i_dividend[sqs_pkg::Q_W-1:0];
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= ge ? diff[sqs_pkg::D_W-1:0] : trial[sqs_pkg::D_W-1:0];
                r_low <= {r_low[sqs_pkg::Q_W-2:0], ge};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_low;
    assign o_rem  = r_rem;

endmodule

### rtl/sqs_stats.sv
// Running minimum/maximum of samples and codes, and saturating clip counters.
// Presents the updated values combinationally; they are stored on commit.
// Depends on sqs_pkg.
module sqs_stats #(
    parameter int COUNT_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_commit,
    input  sqs_pkg::t_upd         i_upd,
    output sqs_pkg::t_stats       o_next
);

    logic signed [sqs_pkg::W_SMP-1:0] r_in_min,   n_in_min;
    logic signed [sqs_pkg::W_SMP-1:0] r_in_max,   n_in_max;
    logic [sqs_pkg::W_CODE-1:0]       r_code_min, n_code_min;
    logic [sqs_pkg::W_CODE-1:0]       r_code_max, n_code_max;
    logic [COUNT_BITS-1:0]            r_low_cnt,  n_low_cnt;
    logic [COUNT_BITS-1:0]            r_high_cnt, n_high_cnt;

    logic signed [sqs_pkg::W_SMP-1:0] b_in_min, b_in_max;
    logic [sqs_pkg::W_CODE-1:0]       b_code_min, b_code_max;
    logic [COUNT_BITS-1:0]            b_low_cnt, b_high_cnt;

    always_comb begin
        // restart: start from reset values, then take this sample as usual
        b_in_min   = i_upd.restart ? sqs_pkg::SMP_MAX : r_in_min;
        b_in_max   = i_upd.restart ? sqs_pkg::SMP_MIN : r_in_max;
        b_code_min = i_upd.restart ? {sqs_pkg::W_CODE{1'b1}} : r_code_min;
        b_code_max = i_upd.restart ? '0 : r_code_max;
        b_low_cnt  = i_upd.restart ? '0 : r_low_cnt;
        b_high_cnt = i_upd.restart ? '0 : r_high_cnt;

        n_in_min   = (i_upd.sample < b_in_min) ? i_upd.sample : b_in_min;
        n_in_max   = (i_upd.sample > b_in_max) ? i_upd.sample : b_in_max;
        n_code_min = (i_upd.code < b_code_min) ? i_upd.code : b_code_min;
        n_code_max = (i_upd.code > b_code_max) ? i_upd.code : b_code_max;
        n_low_cnt  = (i_upd.low_clip && (b_low_cnt != '1))
                   ? b_low_cnt + COUNT_BITS'(1) : b_low_cnt;
        n_high_cnt = (i_upd.high_clip && (b_high_cnt != '1))
                   ? b_high_cnt + COUNT_BITS'(1) : b_high_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_min   <= sqs_pkg::SMP_MAX;
            r_in_max   <= sqs_pkg::SMP_MIN;
            r_code_min <= {sqs_pkg::W_CODE{1'b1}};
            r_code_max <= '0;
            r_low_cnt  <= '0;
            r_high_cnt <= '0;
        end else if (i_commit) begin
            r_in_min   <= n_in_min;
            r_in_max   <= n_in_max;
            r_code_min <= n_code_min;
            r_code_max <= n_code_max;
            r_low_cnt  <= n_low_cnt;
            r_high_cnt <= n_high_cnt;
        end
    end

    assign o_next.in_min   = n_in_min;
    assign o_next.in_max   = n_in_max;
    assign o_next.code_min = n_code_min;
    assign o_next.code_max = n_code_max;

    // ports carry the low bits of the counters, zero-extended when the counters are narrower
    if (COUNT_BITS >= sqs_pkg::W_TOT) begin : g_wide
        assign o_next.low_total  = n_low_cnt[sqs_pkg::W_TOT-1:0];
        assign o_next.high_total = n_high_cnt[sqs_pkg::W_TOT-1:0];
    end else begin : g_narrow
        assign o_next.low_total  = {{(sqs_pkg::W_TOT-COUNT_BITS){1'b0}}, n_low_cnt};
        assign o_next.high_total = {{(sqs_pkg::W_TOT-COUNT_BITS){1'b0}}, n_high_cnt};
    end

endmodule

### rtl/sample_quantizer_with_stats.sv
// Top level of the linear range quantizer with clipping and running statistics:
// APB register file, sequencer, multiply front end and output register.
// Depends on sqs_pkg, sqs_div and sqs_stats.
//
//   channel   | handshake             | payload
//   ----------+-----------------------+------------------------------------------
//   sample in | i_valid / o_ready     | i_sample_in, i_restart_stats
//   result    | o_valid / i_ready     | o_code_out, clip flags, running stats
//   config    | psel, penable, pwrite | paddr, pwdata, prdata, pready (always 1)
//
// A sample inside the range goes from transfer to result through the set-up states
// S_DIFF, S_ABS and S_CLASS (differences, sign fix, classify and multiply), the divider,
// a wait on the divider's done flag, a rounding state and the load of the output register;
// the next transfer is taken only once the sequencer is back in idle. Clipped samples and
// equal range ends skip the divider and the rounding. o_ready is high only while the
// sequencer is idle; a result waiting on i_ready holds the next sample in its output state. Sync reset.
module sample_quantizer_with_stats #(
    parameter int COUNT_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // sample channel
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [sqs_pkg::W_SMP-1:0]   i_sample_in,
    input  logic                               i_restart_stats,
    // result channel
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [sqs_pkg::W_CODE-1:0]         o_code_out,
    output logic                               o_clipped_low,
    output logic                               o_clipped_high,
    output logic signed [sqs_pkg::W_SMP-1:0]   o_seen_in_min,
    output logic signed [sqs_pkg::W_SMP-1:0]   o_seen_in_max,
    output logic [sqs_pkg::W_CODE-1:0]         o_seen_code_min,
    output logic [sqs_pkg::W_CODE-1:0]         o_seen_code_max,
    output logic [sqs_pkg::W_TOT-1:0]          o_low_clip_total,
    output logic [sqs_pkg::W_TOT-1:0]          o_high_clip_total,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [3:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    typedef enum logic [2:0] {
        S_IDLE, S_DIFF, S_ABS, S_CLASS, S_DIV, S_RND, S_OUT
    } t_state;

    // configuration registers
    logic signed [sqs_pkg::W_SMP-1:0] r_range_low;
    logic signed [sqs_pkg::W_SMP-1:0] r_range_high;
    logic [sqs_pkg::W_CODE-1:0]       r_max_code;
    logic                             r_mask_mode;

    logic [1:0] reg_idx;
    logic       cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low  <= '0;
            r_range_high <= sqs_pkg::W_SMP'(65536);
            r_max_code   <= sqs_pkg::W_CODE'(255);
            r_mask_mode  <= 1'b0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                sqs_pkg::REG_RANGE_LOW:  r_range_low  <= pwdata;
                sqs_pkg::REG_RANGE_HIGH: r_range_high <= pwdata;
                sqs_pkg::REG_MAX_CODE:   r_max_code   <= pwdata[sqs_pkg::W_CODE-1:0];
                sqs_pkg::REG_MASK_MODE:  r_mask_mode  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            sqs_pkg::REG_RANGE_LOW:  prdata = r_range_low;
            sqs_pkg::REG_RANGE_HIGH: prdata = r_range_high;
            sqs_pkg::REG_MAX_CODE:   prdata = {16'd0, r_max_code};
            sqs_pkg::REG_MASK_MODE:  prdata = {31'd0, r_mask_mode};
            default:                 prdata = '0;
        endcase
    end

    // sequencer and datapath
    t_state                           r_state;
    logic signed [sqs_pkg::W_SMP-1:0] r_sample;
    logic                             r_restart;
    logic signed [sqs_pkg::W_DIF-1:0] r_num;
    logic signed [sqs_pkg::W_DIF-1:0] r_den;
    logic [sqs_pkg::W_CODE-1:0]       r_code;
    logic                             r_lowc;
    logic                             r_highc;
    logic                             r_out_valid;

    logic                       in_xfer;
    logic                       commit;
    logic                       div_start;
    logic                       div_done;
    logic [sqs_pkg::Q_W-1:0]    quot;
    logic [sqs_pkg::D_W-1:0]    rem;
    logic [sqs_pkg::Q_W-1:0]    mult;
    logic [sqs_pkg::P_W-1:0]    prod;
    logic                       in_range;
    logic [sqs_pkg::Q_W-1:0]    q_rnd;
    logic                       rnd_up;
    sqs_pkg::t_upd              upd;
    sqs_pkg::t_stats            nxt;

    assign o_ready = (r_state == S_IDLE);
    assign in_xfer = i_valid && o_ready;
    assign commit  = (r_state == S_OUT) && (!r_out_valid || i_ready);

    // r_num and r_den are sign-corrected here: r_den >= 0
    assign in_range  = (r_den != sqs_pkg::DIF_ZERO) && (r_num > sqs_pkg::DIF_ZERO)
                       && (r_num < r_den);
    assign mult      = r_mask_mode ? {1'b0, r_max_code}
                                   : {1'b0, r_max_code} + sqs_pkg::Q_W'(1);
    assign prod      = r_num[sqs_pkg::D_W-1:0] * mult;
    assign div_start = (r_state == S_CLASS) && in_range;

    sqs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (prod),
        .i_divisor  (r_den[sqs_pkg::D_W-1:0]),
        .o_done     (div_done),
        .o_quot     (quot),
        .o_rem      (rem)
    );

    // mask mode: round to nearest, halves toward the nearer end of the code range
    always_comb begin
        rnd_up = 1'b0;
        if (r_mask_mode) begin
            if ({rem, 1'b0} > {1'b0, r_den[sqs_pkg::D_W-1:0]}) begin
                rnd_up = 1'b1;
            end else if (({rem, 1'b0} == {1'b0, r_den[sqs_pkg::D_W-1:0]}) && (rem != '0)
                         && ({r_num[sqs_pkg::D_W-1:0], 1'b0}
                             >= {1'b0, r_den[sqs_pkg::D_W-1:0]})) begin
                rnd_up = 1'b1;
            end
        end
        q_rnd = quot + sqs_pkg::Q_W'(rnd_up);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (o_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_sample  <= i_sample_in;
                        r_restart <= i_restart_stats;
                        r_state   <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_num   <= sqs_pkg::W_DIF'(r_sample) - sqs_pkg::W_DIF'(r_range_low);
                    r_den   <= sqs_pkg::W_DIF'(r_range_high) - sqs_pkg::W_DIF'(r_range_low);
                    r_state <= S_ABS;
                end
                S_ABS: begin
                    // reversed ends: flip both so the span is positive
                    if (r_den < sqs_pkg::DIF_ZERO) begin
                        r_num <= -r_num;
                        r_den <= -r_den;
                    end
                    r_state <= S_CLASS;
                end
                S_CLASS: begin
                    r_lowc  <= 1'b0;
                    r_highc <= 1'b0;
                    if (r_den == sqs_pkg::DIF_ZERO) begin
                        r_code  <= r_max_code >> 1;
                        r_state <= S_OUT;
                    end else if (r_num <= sqs_pkg::DIF_ZERO) begin
                        r_code  <= '0;
                        r_lowc  <= 1'b1;
                        r_state <= S_OUT;
                    end else if (r_num >= r_den) begin
                        r_code  <= r_max_code;
                        r_highc <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_RND;
                    end
                end
                S_RND: begin
                    r_code  <= (q_rnd > {1'b0, r_max_code}) ? r_max_code
                                                            : q_rnd[sqs_pkg::W_CODE-1:0];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (commit) begin
                        o_code_out        <= r_code;
                        o_clipped_low     <= r_lowc;
                        o_clipped_high    <= r_highc;
                        o_seen_in_min     <= nxt.in_min;
                        o_seen_in_max     <= nxt.in_max;
                        o_seen_code_min   <= nxt.code_min;
                        o_seen_code_max   <= nxt.code_max;
                        o_low_clip_total  <= nxt.low_total;
                        o_high_clip_total <= nxt.high_total;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_out_valid;

    assign upd.restart   = r_restart;
    assign upd.sample    = r_sample;
    assign upd.code      = r_code;
    assign upd.low_clip  = r_lowc;
    assign upd.high_clip = r_highc;

    sqs_stats #(
        .COUNT_BITS (COUNT_BITS)
    ) u_stats (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (commit),
        .i_upd    (upd),
        .o_next   (nxt)
    );

endmodule

### test/tb.sv
// Self-checking testbench for sample_quantizer_with_stats: APB set-up, random sample traffic,
// a scoreboard class that predicts code, clip flags and running statistics per transfer.
// Depends on sqs_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb;

    localparam int    RESET_CYCLES  = 6;
    localparam int    SETTLE_CYCLES = 30;   // settling time after the last result before new settings
    localparam int    HOLD_CYCLES   = 300;
    localparam int    SETTINGS_PER_PHASE = 4;
    localparam int    ITEMS_PER_SETTING  = 42;
    localparam longint RUN_LIMIT_NS = 2_000_000;

    typedef struct {
        logic [sqs_pkg::W_CODE-1:0]       code;
        logic                             clip_lo;
        logic                             clip_hi;
        logic signed [sqs_pkg::W_SMP-1:0] in_min;
        logic signed [sqs_pkg::W_SMP-1:0] in_max;
        logic [sqs_pkg::W_CODE-1:0]       code_min;
        logic [sqs_pkg::W_CODE-1:0]       code_max;
        logic [sqs_pkg::W_TOT-1:0]        low_tot;
        logic [sqs_pkg::W_TOT-1:0]        high_tot;
    } t_quant_out;

    class t_quant_stats_tracker;
        logic signed [sqs_pkg::W_SMP-1:0] range_lo;
        logic signed [sqs_pkg::W_SMP-1:0] range_hi;
        logic [sqs_pkg::W_CODE-1:0]       max_code;
        logic                             mask_mode;
        logic signed [sqs_pkg::W_SMP-1:0] in_min;
        logic signed [sqs_pkg::W_SMP-1:0] in_max;
        logic [sqs_pkg::W_CODE-1:0]       code_min;
        logic [sqs_pkg::W_CODE-1:0]       code_max;
        logic [sqs_pkg::W_TOT-1:0]        low_cnt;
        logic [sqs_pkg::W_TOT-1:0]        high_cnt;
        t_quant_out                       due_results[$];
        int unsigned                      fail_count;

        function new();
            range_lo   = 0;
            range_hi   = 65536;
            max_code   = 255;
            mask_mode  = 1'b0;
            fail_count = 0;
            clear_stats();
        endfunction

        function void clear_stats();
            in_min   = sqs_pkg::SMP_MAX;
            in_max   = sqs_pkg::SMP_MIN;
            code_min = '1;
            code_max = '0;
            low_cnt  = '0;
            high_cnt = '0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                sqs_pkg::REG_RANGE_LOW:  range_lo  = value;
                sqs_pkg::REG_RANGE_HIGH: range_hi  = value;
                sqs_pkg::REG_MAX_CODE:   max_code  = value[sqs_pkg::W_CODE-1:0];
                sqs_pkg::REG_MASK_MODE:  mask_mode = value[0];
                default: ;
            endcase
        endfunction

        // work out the result of one accepted sample and queue it
        function void note_sample(logic signed [sqs_pkg::W_SMP-1:0] smp, logic restart);
            longint                     num;
            longint                     den;
            longint unsigned            n;
            longint unsigned            d;
            longint unsigned            prod;
            longint unsigned            quo;
            longint unsigned            rem;
            logic [sqs_pkg::W_CODE-1:0] code;
            logic                       lo_c;
            logic                       hi_c;
            t_quant_out                 res;

            lo_c = 1'b0;
            hi_c = 1'b0;
            code = '0;
            if (restart)
                clear_stats();
            if (smp < in_min) in_min = smp;
            if (smp > in_max) in_max = smp;

            if (range_lo == range_hi) begin
                code = max_code >> 1;
            end else begin
                num = longint'(smp) - longint'(range_lo);
                den = longint'(range_hi) - longint'(range_lo);
                if (den < 0) begin
                    num = -num;
                    den = -den;
                end
                if (num <= 0) begin
                    lo_c = 1'b1;
                end else if (num >= den) begin
                    code = max_code;
                    hi_c = 1'b1;
                end else begin
                    n = num;
                    d = den;
                    if (mask_mode) begin
                        prod = n * longint'(max_code);
                        quo  = prod / d;
                        rem  = prod % d;
                        // exact halves go toward the nearer end of the code range
                        if (2 * rem > d)
                            quo = quo + 1;
                        else if (2 * rem == d && rem != 0 && 2 * n >= d)
                            quo = quo + 1;
                    end else begin
                        quo = (n * (longint'(max_code) + 1)) / d;
                    end
                    if (quo > longint'(max_code))
                        quo = max_code;
                    code = quo[sqs_pkg::W_CODE-1:0];
                end
            end

            if (lo_c && low_cnt != '1)  low_cnt  = low_cnt + 1'b1;
            if (hi_c && high_cnt != '1) high_cnt = high_cnt + 1'b1;
            if (code < code_min) code_min = code;
            if (code > code_max) code_max = code;

            res.code     = code;
            res.clip_lo  = lo_c;
            res.clip_hi  = hi_c;
            res.in_min   = in_min;
            res.in_max   = in_max;
            res.code_min = code_min;
            res.code_max = code_max;
            res.low_tot  = low_cnt;
            res.high_tot = high_cnt;
            due_results.push_back(res);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] seen);
            if (want !== seen) begin
                fail_count++;
                $error("%s: expected 0x%0h, got 0x%0h", field, want, seen);
            end
        endfunction

        function void check_result(t_quant_out got);
            t_quant_out want;
            if (due_results.size() == 0) begin
                fail_count++;
                $error("result transfer with no sample outstanding");
                return;
            end
            want = due_results.pop_front();
            compare_field("code_out",        want.code,     got.code);
            compare_field("clipped_low",     want.clip_lo,  got.clip_lo);
            compare_field("clipped_high",    want.clip_hi,  got.clip_hi);
            compare_field("seen_in_min",     want.in_min,   got.in_min);
            compare_field("seen_in_max",     want.in_max,   got.in_max);
            compare_field("seen_code_min",   want.code_min, got.code_min);
            compare_field("seen_code_max",   want.code_max, got.code_max);
            compare_field("low_clip_total",  want.low_tot,  got.low_tot);
            compare_field("high_clip_total", want.high_tot, got.high_tot);
        endfunction
    endclass

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_valid = 1'b0;
    logic                             o_ready;
    logic signed [sqs_pkg::W_SMP-1:0] i_sample_in = '0;
    logic                             i_restart_stats = 1'b0;
    logic                             o_valid;
    logic                             i_ready = 1'b0;
    logic [sqs_pkg::W_CODE-1:0]       o_code_out;
    logic                             o_clipped_low;
    logic                             o_clipped_high;
    logic signed [sqs_pkg::W_SMP-1:0] o_seen_in_min;
    logic signed [sqs_pkg::W_SMP-1:0] o_seen_in_max;
    logic [sqs_pkg::W_CODE-1:0]       o_seen_code_min;
    logic [sqs_pkg::W_CODE-1:0]       o_seen_code_max;
    logic [sqs_pkg::W_TOT-1:0]        o_low_clip_total;
    logic [sqs_pkg::W_TOT-1:0]        o_high_clip_total;
    logic                             psel = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite = 1'b0;
    logic [3:0]                       paddr = '0;
    logic [31:0]                      pwdata = '0;
    logic [31:0]                      prdata;
    logic                             pready;

    t_quant_stats_tracker sb;
    int unsigned send_idle_pct = 30;
    int unsigned recv_idle_pct = 57;
    int unsigned hold_asks = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    sample_quantizer_with_stats dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_sample_in       (i_sample_in),
        .i_restart_stats   (i_restart_stats),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_code_out        (o_code_out),
        .o_clipped_low     (o_clipped_low),
        .o_clipped_high    (o_clipped_high),
        .o_seen_in_min     (o_seen_in_min),
        .o_seen_in_max     (o_seen_in_max),
        .o_seen_code_min   (o_seen_code_min),
        .o_seen_code_max   (o_seen_code_max),
        .o_low_clip_total  (o_low_clip_total),
        .o_high_clip_total (o_high_clip_total),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always #2 i_clk = ~i_clk;

    // result side: random back-pressure, plus a long hold-off whenever one is asked for
    always @(negedge i_clk) begin
        if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_ready = 1'b0;
        end else begin
            i_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_quant_out got;
        if (i_rst_n && o_valid && i_ready) begin
            got.code     = o_code_out;
            got.clip_lo  = o_clipped_low;
            got.clip_hi  = o_clipped_high;
            got.in_min   = o_seen_in_min;
            got.in_max   = o_seen_in_max;
            got.code_min = o_seen_code_min;
            got.code_max = o_seen_code_max;
            got.low_tot  = o_low_clip_total;
            got.high_tot = o_high_clip_total;
            sb.check_result(got);
        end
    end

    // called and returns at a falling edge
    task automatic send_sample(input logic signed [sqs_pkg::W_SMP-1:0] smp,
                               input logic restart);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid         = 1'b1;
        i_sample_in     = smp;
        i_restart_stats = restart;
        do @(posedge i_clk); while (!o_ready);
        sb.note_sample(smp, restart);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic drain();
        i_valid = 1'b0;
        while (sb.due_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apply_setting(input logic [31:0] lo, input logic [31:0] hi,
                                 input logic [15:0] mc, input logic mm);
        drain();
        write_reg(sqs_pkg::REG_RANGE_LOW, lo);
        write_reg(sqs_pkg::REG_RANGE_HIGH, hi);
        write_reg(sqs_pkg::REG_MAX_CODE, {16'h0, mc});
        write_reg(sqs_pkg::REG_MASK_MODE, {31'h0, mm});
    endtask

    // kinds cycle so every phase sees the widest range as well as random ranges
    task automatic random_setting(input int unsigned kind);
        logic [31:0] lo;
        logic [31:0] hi;
        logic [15:0] mc;
        lo = $urandom;
        mc = $urandom_range(65535, 1);
        case (kind)
            0: begin
                if ($urandom_range(1))
                    hi = $urandom;
                else if ($urandom_range(1))
                    hi = lo + $urandom_range(1 << 20, 1);
                else
                    hi = lo - $urandom_range(1 << 20, 1);
            end
            1: begin
                lo = sqs_pkg::SMP_MIN;
                hi = sqs_pkg::SMP_MAX;
                mc = 16'hFFFF;
            end
            2: begin
                lo = sqs_pkg::SMP_MAX;
                hi = sqs_pkg::SMP_MIN;
            end
            3: hi = lo;
            default: begin
                hi = lo + $urandom_range(4, 1);
                mc = $urandom_range(1) ? 16'hFFFF : 16'd1;
            end
        endcase
        apply_setting(lo, hi, mc, $urandom_range(1));
    endtask

    // mostly samples inside the range, some on and next to the ends, the rest anywhere
    function automatic logic signed [sqs_pkg::W_SMP-1:0] pick_sample();
        longint          span;
        longint          mag;
        longint unsigned rnd;
        longint          pos;
        int unsigned     sel;
        sel  = $urandom_range(99);
        span = longint'(sb.range_hi) - longint'(sb.range_lo);
        mag  = (span < 0) ? -span : span;
        if (sel < 60) begin
            rnd = {$urandom, $urandom};
            rnd = rnd % longint'(mag + 1);
            pos = longint'(sb.range_lo) + ((span < 0) ? -longint'(rnd) : longint'(rnd));
            return pos[sqs_pkg::W_SMP-1:0];
        end else if (sel < 75) begin
            case ($urandom_range(5))
                0: return sb.range_lo;
                1: return sb.range_hi;
                2: return sb.range_lo + 1;
                3: return sb.range_lo - 1;
                4: return sb.range_hi + 1;
                default: return sb.range_hi - 1;
            endcase
        end
        return $urandom;
    endfunction

    initial begin
        #(RUN_LIMIT_NS);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: ends, both clips, extremes of the sample, a restart
        send_sample(0, 1'b0);
        send_sample(1, 1'b0);
        send_sample(32768, 1'b0);
        send_sample(65535, 1'b0);
        send_sample(65536, 1'b0);
        send_sample(sqs_pkg::SMP_MAX, 1'b0);
        send_sample(sqs_pkg::SMP_MIN, 1'b1);
        send_sample(-1, 1'b0);

        // mask mode halves: 1/4 rounds down, 3/4 rounds up
        apply_setting(0, 4, 2, 1'b1);
        send_sample(1, 1'b0);
        send_sample(3, 1'b0);
        send_sample(2, 1'b0);
        send_sample(1, 1'b1);

        // equal ends
        apply_setting(100, 100, 7, 1'b0);
        send_sample(100, 1'b0);
        send_sample(sqs_pkg::SMP_MIN, 1'b0);

        // reversed ends with a zero max code
        apply_setting(1000, -1000, 0, 1'b1);
        send_sample(0, 1'b0);
        send_sample(2000, 1'b0);
        send_sample(-2000, 1'b0);
        send_sample(500, 1'b0);

        // widest span
        apply_setting(sqs_pkg::SMP_MIN, sqs_pkg::SMP_MAX, 16'hFFFF, 1'b0);
        send_sample(sqs_pkg::SMP_MIN, 1'b0);
        send_sample(sqs_pkg::SMP_MAX, 1'b0);
        send_sample(0, 1'b0);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 30;
                    recv_idle_pct = 57;
                end
                1: begin
                    send_idle_pct = 57;
                    recv_idle_pct = 30;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int k = 0; k < SETTINGS_PER_PHASE; k++) begin
                random_setting((phase * SETTINGS_PER_PHASE + k) % 5);
                // results stall for a long stretch while samples keep coming
                if (phase == 0 && k == 1)
                    hold_asks++;
                repeat (ITEMS_PER_SETTING)
                    send_sample(pick_sample(), $urandom_range(19) == 0);
            end
        end

        drain();
        if (sb.fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
rtl/sqs_pkg.sv
rtl/sqs_div.sv
rtl/sqs_stats.sv
rtl/sample_quantizer_with_stats.sv
test/tb.sv
